[rtl/core/ipw_calc_pkg.sv]
// ipw_calc_pkg: shared constants and arithmetic helpers for the injector pulse width block
// no dependencies; imported by ipw_div, injector_pulse_width_calc_top and tb
package ipw_calc_pkg;

  // map factor selection codes (config register map_mode)
  typedef enum logic [1:0] {
    MAP_OFF  = 2'd0,
    MAP_PCT  = 2'd1,
    MAP_BARO = 2'd2,
    MAP_RSVD = 2'd3
  } map_mode_e;

  // config register indexes
  typedef enum logic [2:0] {
    REG_MAP_MODE        = 3'd0,
    REG_INCLUDE_AFR     = 3'd1,
    REG_EGO_WIDEBAND    = 3'd2,
    REG_EGO_DELAY       = 3'd3,
    REG_INCORPORATE_AFR = 3'd4,
    REG_STOICH_AFR      = 3'd5,
    REG_AE_ADDER_MODE   = 3'd6
  } cfg_reg_e;

  localparam int unsigned QW = 16;  // factor width
  localparam logic [25:0] Div100K = 26'd42949672;  // floor(2^32 / 100)
  localparam logic [QW-1:0] QSat = '1;

  // floor(n / 100) by reciprocal multiply and one correction step
  function automatic logic [31:0] div100(input logic [31:0] n);
    logic [57:0] p;
    logic [25:0] q;
    logic [32:0] r;
    begin
      p = {26'd0, n} * {32'd0, Div100K};
      q = p[57:32];
      r = {1'b0, n} - ({7'd0, q} * 33'd100);
      if (r >= 33'd100) begin
        q = q + 26'd1;
      end
      div100 = {6'd0, q};
    end
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    begin
      sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    end
  endfunction

endpackage

[rtl/core/ipw_div.sv]
// ipw_div: pipelined restoring divider, STEP quotient bits per stage, saturating q7 quotient
// depends on ipw_calc_pkg
module ipw_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 8,
  parameter int STEP  = 3
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [ipw_calc_pkg::QW-1:0] quot_o
);
  import ipw_calc_pkg::*;

  localparam int NSTG = (NUM_W + STEP - 1) / STEP;
  localparam int TOT  = NSTG * STEP;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  logic [TOT-1:0]   nq_s  [NSTG+1];
  logic [DEN_W-1:0] rem_s [NSTG+1];
  logic [DEN_W-1:0] den_s [NSTG+1];

  assign nq_s[0]  = TOT'(num_i);
  assign rem_s[0] = '0;
  assign den_s[0] = den_i;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [TOT-1:0]   nq_d;
    logic [DEN_W-1:0] rem_d;

    always_comb begin
      logic [DEN_W:0] r;
      nq_d  = nq_s[s];
      rem_d = rem_s[s];
      for (int k = 0; k < STEP; k++) begin
        r    = {rem_d, nq_d[TOT-1]};
        nq_d = {nq_d[TOT-2:0], 1'b0};
        if (r >= {1'b0, den_s[s]}) begin
          r       = r - {1'b0, den_s[s]};
          nq_d[0] = 1'b1;
        end
        rem_d = r[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_s[s+1]  <= nq_d;
        rem_s[s+1] <= rem_d;
        den_s[s+1] <= den_s[s];
      end
    end
  end

  always_comb begin
    if (den_s[NSTG] == '0) begin
      quot_o = QSat;
    end else if (|nq_s[NSTG][TOT-1:QW]) begin
      quot_o = QSat;
    end else begin
      quot_o = nq_s[NSTG][QW-1:0];
    end
  end

endmodule

[rtl/core/injector_pulse_width_calc_top.sv]
// injector_pulse_width_calc_top: pipelined injector pulse width calculator
// depends on ipw_calc_pkg and ipw_div
//
// usage:
// - input channel (in_valid_i/in_ready_o) takes one word of engine data per cycle unless stalled
// - output channel (out_valid_o/out_ready_i) gives one word per input word, in order:
//   pulse_width_o in us, saturated at 65535, and req_invalid_o
// - config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i with cfg_data_i;
//   always ready, write only while the pipeline is empty
// throughput: one word per cycle while the pipeline is not stalled
// pipeline: 11 register stages, most of them in the two q7 dividers (6 stages of 3 quotient
//   bits each), then one stage per factor multiply
// stall: the whole pipeline holds while the output register is full and not taken;
//   in_ready_o drops in that case, nothing is lost or repeated
// reset: all valid bits clear, config goes to defaults (stoich_afr 147, rest 0)
module injector_pulse_width_calc_top #(
  parameter int MAX_REQ_FUEL    = 65535,
  parameter int MAX_MAP         = 511,
  parameter int CORR_LIMIT_LOW  = 256,
  parameter int CORR_LIMIT_HIGH = 511
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] base_fuel_i,
  input  logic [7:0]  vol_eff_i,
  input  logic [9:0]  manifold_kpa_i,
  input  logic [15:0] corr_percent_i,
  input  logic [15:0] open_time_i,
  input  logic [7:0]  baro_kpa_i,
  input  logic [7:0]  o2_afr_i,
  input  logic [7:0]  afr_target_i,
  input  logic [7:0]  run_seconds_i,
  input  logic        accel_active_i,
  input  logic [15:0] ae_percent_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] pulse_width_o,
  output logic        req_invalid_o
);
  import ipw_calc_pkg::*;

  localparam int NUM_W   = 17;
  localparam int DEN_W   = 8;
  localparam int STEP    = 3;
  localparam int DIV_LAT = (NUM_W + STEP - 1) / STEP;

  localparam logic [16:0] ReqMax = 17'(MAX_REQ_FUEL);
  localparam logic [9:0]  MapMax = 10'(MAX_MAP);
  localparam logic [16:0] CorrLo = 17'(CORR_LIMIT_LOW);
  localparam logic [16:0] CorrHi = 17'(CORR_LIMIT_HIGH);

  // ---------------------------------------------------------------- config
  logic [1:0] map_mode_q;
  logic       incl_afr_q, ego_wide_q, incorp_afr_q, ae_adder_q;
  logic [7:0] ego_delay_q, stoich_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q   <= MAP_OFF;
      incl_afr_q   <= 1'b0;
      ego_wide_q   <= 1'b0;
      ego_delay_q  <= 8'd0;
      incorp_afr_q <= 1'b0;
      stoich_q     <= 8'd147;
      ae_adder_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAP_MODE:        map_mode_q   <= cfg_data_i[1:0];
        REG_INCLUDE_AFR:     incl_afr_q   <= cfg_data_i[0];
        REG_EGO_WIDEBAND:    ego_wide_q   <= cfg_data_i[0];
        REG_EGO_DELAY:       ego_delay_q  <= cfg_data_i;
        REG_INCORPORATE_AFR: incorp_afr_q <= cfg_data_i[0];
        REG_STOICH_AFR:      stoich_q     <= cfg_data_i;
        REG_AE_ADDER_MODE:   ae_adder_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  // global advance: everything moves when the output register is free or taken
  localparam int NV = DIV_LAT + 5;  // A, B..aligned, C, D, E, F
  logic [NV-1:0] vld_q;
  logic          en;

  assign en          = !vld_q[NV-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage A
  // factors by constant divide, corrections shift, divider operands, ae product
  typedef struct packed {
    logic [15:0]      req;
    logic [8:0]       ve_f;
    logic [1:0]       map_sel;
    logic [15:0]      map_pct;
    logic             afr_on;
    logic [2:0]       sh;
    logic [16:0]      corr_f;
    logic [15:0]      open;
    logic [31:0]      ae_prod;
    logic             invalid;
    logic [NUM_W-1:0] map_num;
    logic [DEN_W-1:0] baro;
    logic [NUM_W-1:0] afr_num;
    logic [DEN_W-1:0] target;
  } stage_a_t;

  stage_a_t a_d, a_q;

  always_comb begin
    logic [9:0]  mapc;
    logic        use_o2, use_st, ae_on;
    logic [31:0] ve_t, map_t, corr_t;
    logic [22:0] corr_sh;
    mapc   = (manifold_kpa_i > MapMax) ? MapMax : manifold_kpa_i;
    use_o2 = incl_afr_q && ego_wide_q && (run_seconds_i > ego_delay_q);
    use_st = incorp_afr_q && !incl_afr_q;
    ae_on  = accel_active_i && ae_adder_q && (ae_percent_i > 16'd100);

    ve_t  = div100({17'd0, vol_eff_i, 7'd0});
    map_t = div100({15'd0, mapc, 7'd0});

    if ({1'b0, corr_percent_i} < CorrLo) begin
      a_d.sh  = 3'd7;
      corr_sh = {corr_percent_i, 7'd0};
    end else if ({1'b0, corr_percent_i} < CorrHi) begin
      a_d.sh  = 3'd6;
      corr_sh = {1'b0, corr_percent_i, 6'd0};
    end else begin
      a_d.sh  = 3'd5;
      corr_sh = {2'b0, corr_percent_i, 5'd0};
    end
    corr_t = div100({9'd0, corr_sh});

    a_d.req     = base_fuel_i;
    a_d.ve_f    = ve_t[8:0];
    unique case (map_mode_q)
      MAP_PCT:  a_d.map_sel = MAP_PCT;
      MAP_BARO: a_d.map_sel = MAP_BARO;
      default:  a_d.map_sel = MAP_OFF;
    endcase
    a_d.map_pct = (|map_t[31:16]) ? QSat : map_t[15:0];
    a_d.afr_on  = use_o2 || use_st;
    a_d.corr_f  = corr_t[16:0];
    a_d.open    = open_time_i;
    a_d.ae_prod = ae_on ? ({16'd0, base_fuel_i} * {16'd0, (ae_percent_i - 16'd100)}) : 32'd0;
    a_d.invalid = {1'b0, base_fuel_i} > ReqMax;
    a_d.map_num = {mapc, 7'd0};
    a_d.baro    = baro_kpa_i;
    a_d.afr_num = {2'd0, (use_o2 ? o2_afr_i : stoich_q), 7'd0};
    a_d.target  = afr_target_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [QW-1:0] map_quot, afr_quot;

  ipw_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .STEP(STEP)) u_div_map (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (a_q.map_num),
    .den_i  (a_q.baro),
    .quot_o (map_quot)
  );

  ipw_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .STEP(STEP)) u_div_afr (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (a_q.afr_num),
    .den_i  (a_q.target),
    .quot_o (afr_quot)
  );

  // ---------------------------------------------------------------- stage B + delay
  // base product and ae term, then wait alongside the dividers
  typedef struct packed {
    logic [31:0] x;
    logic [1:0]  map_sel;
    logic [15:0] map_pct;
    logic [15:0] map_q;
    logic        afr_on;
    logic [15:0] afr_q;
    logic [2:0]  sh;
    logic [16:0] corr_f;
    logic [15:0] open;
    logic [31:0] ae_term;
    logic        invalid;
  } pipe_t;

  pipe_t b_d;
  pipe_t dl_q [DIV_LAT];

  always_comb begin
    logic [24:0] p;
    p           = {9'd0, a_q.req} * {16'd0, a_q.ve_f};
    b_d.x       = {14'd0, p[24:7]};
    b_d.map_sel = a_q.map_sel;
    b_d.map_pct = a_q.map_pct;
    b_d.map_q   = '0;
    b_d.afr_on  = a_q.afr_on;
    b_d.afr_q   = '0;
    b_d.sh      = a_q.sh;
    b_d.corr_f  = a_q.corr_f;
    b_d.open    = a_q.open;
    b_d.ae_term = div100(a_q.ae_prod);
    b_d.invalid = a_q.invalid;
  end

  // one delay slot per divider stage keeps the word next to its quotients
  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= b_d;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- stage C: map factor
  pipe_t c_d, c_q;

  always_comb begin
    logic [47:0] p;
    logic [15:0] f;
    c_d       = dl_q[DIV_LAT-1];
    c_d.map_q = map_quot;
    c_d.afr_q = afr_quot;
    f = (c_d.map_sel == MAP_PCT) ? c_d.map_pct : map_quot;
    p = {16'd0, c_d.x} * {32'd0, f};
    if (c_d.map_sel != MAP_OFF) begin
      c_d.x = sat32({23'd0, p[47:7]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
    end
  end

  // ---------------------------------------------------------------- stage D: afr factor
  pipe_t d_d, d_q;

  always_comb begin
    logic [47:0] p;
    d_d = c_q;
    p   = {16'd0, c_q.x} * {32'd0, c_q.afr_q};
    if (c_q.afr_on) begin
      d_d.x = sat32({23'd0, p[47:7]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= d_d;
    end
  end

  // ---------------------------------------------------------------- stage E: corrections
  pipe_t e_d, e_q;

  always_comb begin
    logic [48:0] p;
    e_d = d_q;
    p   = {17'd0, d_q.x} * {32'd0, d_q.corr_f};
    case (d_q.sh)
      3'd7:    e_d.x = sat32({22'd0, p[48:7]});
      3'd6:    e_d.x = sat32({21'd0, p[48:6]});
      default: e_d.x = sat32({20'd0, p[48:5]});
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= e_d;
    end
  end

  // ---------------------------------------------------------------- stage F: output word
  logic [15:0] pw_d, pw_q;
  logic        inv_q;

  always_comb begin
    logic [33:0] total;
    total = {2'd0, e_q.x} + {18'd0, e_q.open} + {2'd0, e_q.ae_term};
    if (e_q.invalid || (e_q.x == 32'd0)) begin
      pw_d = 16'd0;  // invalid request or fuel cut
    end else if (|total[33:16]) begin
      pw_d = 16'hFFFF;
    end else begin
      pw_d = total[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q  <= pw_d;
      inv_q <= e_q.invalid;
    end
  end

  assign pulse_width_o = pw_q;
  assign req_invalid_o = inv_q;

endmodule

[test/tb.sv]
// tb: self-checking testbench for injector_pulse_width_calc_top
// depends on ipw_calc_pkg and the block's rtl; drives words, predicts and compares every result
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipw_calc_pkg::*;

  localparam int MAX_MAP_KPA = 511;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [15:0] base_fuel;
    logic [7:0]  vol_eff;
    logic [9:0]  manifold_kpa;
    logic [15:0] corr_percent;
    logic [15:0] open_time;
    logic [7:0]  baro_kpa;
    logic [7:0]  o2_afr;
    logic [7:0]  afr_target;
    logic [7:0]  run_seconds;
    logic        accel_active;
    logic [15:0] ae_percent;
  } engine_word_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        req_invalid;
  } pulse_t;

  class pulse_scoreboard;
    map_mode_e   map_mode;
    bit          include_afr, ego_wideband, incorporate_afr, ae_adder_mode;
    logic [7:0]  ego_delay, stoich_afr;
    pulse_t      expected_q[$];
    int          errors;

    function new();
      map_mode = MAP_OFF;
      include_afr = 0;
      ego_wideband = 0;
      incorporate_afr = 0;
      ae_adder_mode = 0;
      ego_delay = 0;
      stoich_afr = 8'd147;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_MAP_MODE:        map_mode = map_mode_e'(val[1:0]);
        REG_INCLUDE_AFR:     include_afr = val[0];
        REG_EGO_WIDEBAND:    ego_wideband = val[0];
        REG_EGO_DELAY:       ego_delay = val;
        REG_INCORPORATE_AFR: incorporate_afr = val[0];
        REG_STOICH_AFR:      stoich_afr = val;
        REG_AE_ADDER_MODE:   ae_adder_mode = val[0];
        default: ;
      endcase
    endfunction

    // ratio in q9.7, all ones on a zero divisor, saturated to 16 bits
    function logic [31:0] ratio_q7(logic [31:0] num, logic [31:0] den);
      logic [31:0] q;
      if (den == 0) return 32'hFFFF;
      q = (num << 7) / den;
      return (q > 32'hFFFF) ? 32'hFFFF : q;
    endfunction

    function logic [31:0] scale(logic [31:0] x, logic [31:0] f, int unsigned sh);
      logic [63:0] p;
      p = ({32'd0, x} * {32'd0, f}) >> sh;
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function pulse_t pulse_width_of(engine_word_t w);
      logic [31:0] x, mapv, f;
      logic [63:0] total;
      int unsigned sh;
      pulse_t r;
      mapv = (w.manifold_kpa > MAX_MAP_KPA) ? MAX_MAP_KPA : w.manifold_kpa;
      x = scale(w.base_fuel, ({24'd0, w.vol_eff} << 7) / 100, 7);
      if (map_mode == MAP_PCT) begin
        f = (mapv << 7) / 100;
        x = scale(x, (f > 32'hFFFF) ? 32'hFFFF : f, 7);
      end else if (map_mode == MAP_BARO) begin
        x = scale(x, ratio_q7(mapv, w.baro_kpa), 7);
      end
      if (include_afr && ego_wideband && w.run_seconds > ego_delay) begin
        x = scale(x, ratio_q7(w.o2_afr, w.afr_target), 7);
      end else if (incorporate_afr && !include_afr) begin
        x = scale(x, ratio_q7(stoich_afr, w.afr_target), 7);
      end
      // correction shift picked by size so the factor keeps precision
      if (w.corr_percent < 256) sh = 7;
      else if (w.corr_percent < 511) sh = 6;
      else sh = 5;
      x = scale(x, ({16'd0, w.corr_percent} << sh) / 100, sh);
      total = x;
      if (x != 0) begin
        total += w.open_time;
        if (w.accel_active && ae_adder_mode && w.ae_percent > 100)
          total += ({48'd0, w.base_fuel} * {48'd0, w.ae_percent - 16'd100}) / 100;
        if (total > 64'hFFFF) total = 64'hFFFF;
      end
      r.pulse_width = total[15:0];
      r.req_invalid = 1'b0;  // every 16-bit base fuel is valid at the default limit
      return r;
    endfunction

    function void note_word(engine_word_t w);
      expected_q.push_back(pulse_width_of(w));
    endfunction

    function void check_result(pulse_t got);
      pulse_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pw=%0d inv=%0b", got.pulse_width,
                                   got.req_invalid);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.pulse_width !== exp_r.pulse_width || got.req_invalid !== exp_r.req_invalid) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pw=%0d inv=%0b, got pw=%0d inv=%0b",
                   exp_r.pulse_width, exp_r.req_invalid, got.pulse_width, got.req_invalid);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  engine_word_t word_d = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] pulse_width_o;
  logic req_invalid_o;

  pulse_scoreboard sb = new();
  bit idle_en = 1'b1;      // random gaps on both sides
  bit hold_req = 1'b0;     // one long receiver hold-off
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  injector_pulse_width_calc_top u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .base_fuel_i(word_d.base_fuel), .vol_eff_i(word_d.vol_eff),
    .manifold_kpa_i(word_d.manifold_kpa), .corr_percent_i(word_d.corr_percent),
    .open_time_i(word_d.open_time), .baro_kpa_i(word_d.baro_kpa),
    .o2_afr_i(word_d.o2_afr), .afr_target_i(word_d.afr_target),
    .run_seconds_i(word_d.run_seconds), .accel_active_i(word_d.accel_active),
    .ae_percent_i(word_d.ae_percent),
    .out_valid_o, .out_ready_i, .pulse_width_o, .req_invalid_o
  );

  // monitors: everything sampled at the rising edge, inputs move on the falling one
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_word(word_d);
    if (out_valid_o && out_ready_i) sb.check_result('{pulse_width_o, req_invalid_o});
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long means a hang
  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // receiver: ready bursts, random stalls, and one long hold to back up the pipeline
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // valid stays up between back-to-back words; only a gap lowers it
  task automatic send_word(input engine_word_t w);
    @(negedge clk_i);
    word_d <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick16(input logic [15:0] typ_lo, input logic [15:0] typ_hi);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(typ_lo, typ_hi));
    endcase
  endfunction

  function automatic logic [7:0] pick8(input logic [7:0] typ_lo, input logic [7:0] typ_hi);
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      2: return 8'($urandom);
      default: return 8'($urandom_range(typ_lo, typ_hi));
    endcase
  endfunction

  // mostly engine-like values so results stay mid-range, with extremes mixed in
  function automatic engine_word_t rand_word();
    engine_word_t w;
    w.base_fuel = pick16(16'd500, 16'd20000);
    w.vol_eff = pick8(8'd20, 8'd160);
    w.manifold_kpa = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(20, 250));
    case ($urandom_range(0, 3))
      0: w.corr_percent = 16'($urandom_range(0, 255));
      1: w.corr_percent = 16'($urandom_range(256, 510));
      2: w.corr_percent = pick16(16'd511, 16'd2000);
      default: w.corr_percent = 16'($urandom_range(70, 160));
    endcase
    w.open_time = pick16(16'd300, 16'd1500);
    w.baro_kpa = pick8(8'd80, 8'd105);
    w.o2_afr = pick8(8'd100, 8'd200);
    w.afr_target = pick8(8'd100, 8'd200);
    w.run_seconds = 8'($urandom);
    w.accel_active = 1'($urandom);
    w.ae_percent = pick16(16'd50, 16'd300);
    return w;
  endfunction

  task automatic write_all(input map_mode_e mm, input bit inc, input bit wb, input logic [7:0] dly,
                           input bit inco, input logic [7:0] st, input bit ae);
    cfg_write(REG_MAP_MODE, 8'(mm));
    cfg_write(REG_INCLUDE_AFR, 8'(inc));
    cfg_write(REG_EGO_WIDEBAND, 8'(wb));
    cfg_write(REG_EGO_DELAY, dly);
    cfg_write(REG_INCORPORATE_AFR, 8'(inco));
    cfg_write(REG_STOICH_AFR, st);
    cfg_write(REG_AE_ADDER_MODE, 8'(ae));
  endtask

  task automatic random_phase(input int n);
    repeat (n) send_word(rand_word());
    drain();
  endtask

  initial begin
    engine_word_t w;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset config: zero word, all-ones word, zero ve, each correction band
    send_word('0);
    send_word('1);
    w = rand_word(); w.vol_eff = 0; send_word(w);
    w = rand_word(); w.vol_eff = 8'd100; w.corr_percent = 16'd255; send_word(w);
    w.corr_percent = 16'd256; send_word(w);
    w.corr_percent = 16'd510; send_word(w);
    w.corr_percent = 16'd511; send_word(w);
    w.corr_percent = 16'd0; send_word(w);
    w.corr_percent = 16'hFFFF; w.base_fuel = 16'hFFFF; w.vol_eff = 8'hFF; send_word(w);
    drain();

    // directed: map relative to baro, stoich ratio, adder mode; then map percent and wideband o2 around the ego delay
    write_all(MAP_BARO, 1'b0, 1'b0, 8'd0, 1'b1, 8'd147, 1'b1);
    w = rand_word(); w.vol_eff = 8'd100; w.corr_percent = 16'd100; w.baro_kpa = 0; send_word(w);
    w.baro_kpa = 8'd100; w.manifold_kpa = 10'h3FF; send_word(w);
    w.manifold_kpa = 10'd512; send_word(w);
    w.manifold_kpa = 10'd511; w.afr_target = 0; send_word(w);
    w.afr_target = 8'd147; w.accel_active = 1; w.ae_percent = 16'd99; send_word(w);
    w.ae_percent = 16'd100; send_word(w);
    w.ae_percent = 16'd101; send_word(w);
    w.ae_percent = 16'hFFFF; w.base_fuel = 16'hFFFF; send_word(w);
    w.vol_eff = 0; send_word(w);  // fuel cut drops opening time and ae
    drain();
    write_all(MAP_PCT, 1'b1, 1'b1, 8'd10, 1'b0, 8'd0, 1'b0);
    w = rand_word(); w.run_seconds = 8'd10; send_word(w);
    w.run_seconds = 8'd11; send_word(w);
    w.afr_target = 0; send_word(w);
    drain();

    // random phases through a spread of settings, extremes included
    write_all(MAP_RSVD, 1'b1, 1'b0, 8'd255, 1'b1, 8'd255, 1'b1);
    random_phase(120);
    write_all(MAP_BARO, 1'b1, 1'b1, 8'd0, 1'b0, 8'd147, 1'b1);
    random_phase(120);
    write_all(MAP_PCT, 1'b1, 1'b1, 8'd255, 1'b1, 8'd0, 1'b0);
    random_phase(120);
    write_all(MAP_OFF, 1'b0, 1'b1, 8'd128, 1'b1, 8'd0, 1'b1);
    // back up the pipeline: long receiver hold while words keep coming
    hold_req = 1'b1;
    random_phase(120);
    repeat (6) begin
      write_all(map_mode_e'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 8'($urandom),
                1'($urandom), 8'($urandom), 1'($urandom));
      random_phase(120);
    end
    // closing stretch with no idling on either side
    idle_en = 1'b0;
    write_all(MAP_BARO, 1'b0, 1'b1, 8'd100, 1'b1, 8'd147, 1'b1);
    random_phase(230);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/ipw_calc_pkg.sv
rtl/core/ipw_div.sv
rtl/core/injector_pulse_width_calc_top.sv
test/tb.sv
